// ----- src/lbsm_pkg.sv -----
`default_nettype none

package lbsm_pkg;

    localparam int CW = 13;
    localparam int XW = 12;
    localparam int OW = 26;
    localparam int BW = 3;
    localparam int IW = 3;
    localparam int DIM_W = 14;
    localparam int DIV_STEPS = CW;
    localparam int MAX_DIMENSION_DEF = 4096;
    localparam int LATENCY = 3 + DIV_STEPS + 3 + DIV_STEPS + 2;

    localparam logic [CW-1:0] SIZE_RESET = CW'(1);
    localparam logic [BW-1:0] BPP_RESET = BW'(3);

    typedef enum logic [IW-1:0] {
        REG_SOURCE_WIDTH    = 3'd0,
        REG_SOURCE_HEIGHT   = 3'd1,
        REG_TARGET_WIDTH    = 3'd2,
        REG_TARGET_HEIGHT   = 3'd3,
        REG_BYTES_PER_PIXEL = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [XW-1:0] out_x;
        logic [XW-1:0] out_y;
    } item_t;

    typedef struct packed {
        logic          geometry_ok;
        logic          in_picture;
        logic [XW-1:0] src_x;
        logic [XW-1:0] src_y;
        logic [OW-1:0] src_byte_offset;
        logic [OW-1:0] dst_byte_offset;
    } result_t;

    typedef struct packed {
        logic [XW-1:0] ox;
        logic [XW-1:0] oy;
        logic [CW-1:0] sw;
        logic [CW-1:0] sh;
        logic [CW-1:0] tw;
        logic [CW-1:0] th;
        logic [BW-1:0] bpp;
        logic          bad;
        logic          tall;
    } geo_t;

    typedef struct packed {
        logic [XW-1:0] ox;
        logic [XW-1:0] oy;
        logic [CW-1:0] sw;
        logic [CW-1:0] tw;
        logic [BW-1:0] bpp;
        logic          ok;
    } map_t;

endpackage

`default_nettype wire

// ----- src/lbsm_div_cell.sv -----
`default_nettype none

module lbsm_div_cell #(
    parameter int W  = 13,
    parameter int PW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [W-1:0]  in_rem,
    input  wire logic [W-1:0]  in_lowq,
    input  wire logic [W-1:0]  in_div,
    input  wire logic [PW-1:0] in_pay,
    output logic               out_valid,
    output logic [W-1:0]       out_rem,
    output logic [W-1:0]       out_lowq,
    output logic [W-1:0]       out_div,
    output logic [PW-1:0]      out_pay
);

    logic          valid_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  lowq_reg;
    logic [W-1:0]  lowq_next;
    logic [W-1:0]  div_reg;
    logic [PW-1:0] pay_reg;
    logic [W:0]    trial;
    logic          fit;

    always_comb
    begin
        trial     = {in_rem, in_lowq[W-1]};
        fit       = trial >= {1'b0, in_div};
        rem_next  = fit ? W'(trial - {1'b0, in_div}) : trial[W-1:0];
        lowq_next = {in_lowq[W-2:0], fit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lowq_reg <= lowq_next;
        div_reg  <= in_div;
        pay_reg  <= in_pay;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_lowq  = lowq_reg;
    assign out_div   = div_reg;
    assign out_pay   = pay_reg;

endmodule

`default_nettype wire

// ----- src/lbsm_div_chain.sv -----
`default_nettype none

module lbsm_div_chain #(
    parameter int W  = 13,
    parameter int PW = 1
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic [2*W-1:0]  in_num,
    input  wire logic [W-1:0]    in_div,
    input  wire logic [PW-1:0]   in_pay,
    output logic                 out_valid,
    output logic [W-1:0]         out_quot,
    output logic [PW-1:0]        out_pay
);

    logic          valid_s [W+1];
    logic [W-1:0]  rem_s   [W+1];
    logic [W-1:0]  lowq_s  [W+1];
    logic [W-1:0]  div_s   [W+1];
    logic [PW-1:0] pay_s   [W+1];

    assign valid_s[0] = in_valid;
    assign rem_s[0]   = in_num[2*W-1:W];
    assign lowq_s[0]  = in_num[W-1:0];
    assign div_s[0]   = in_div;
    assign pay_s[0]   = in_pay;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        lbsm_div_cell #(
            .W  (W),
            .PW (PW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_s[i]),
            .in_rem    (rem_s[i]),
            .in_lowq   (lowq_s[i]),
            .in_div    (div_s[i]),
            .in_pay    (pay_s[i]),
            .out_valid (valid_s[i+1]),
            .out_rem   (rem_s[i+1]),
            .out_lowq  (lowq_s[i+1]),
            .out_div   (div_s[i+1]),
            .out_pay   (pay_s[i+1])
        );
    end

    assign out_valid = valid_s[W];
    assign out_quot  = lowq_s[W];
    assign out_pay   = pay_s[W];

endmodule

`default_nettype wire

// ----- src/letterbox_nearest_scaler_map.sv -----
// Channel   Handshake              Payload
// item      start / busy           item    (out_x, out_y)
// result    done (strobe)          result  (geometry_ok .. dst_byte_offset)
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One coordinate per cycle; busy and cfg_ready stay at their idle values.
// The pipeline holds two rows of 13 divider cells (drawn size, then source
// column and row side by side) plus eight arithmetic stages.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot stall; each result shows on done for one cycle.
`default_nettype none

module letterbox_nearest_scaler_map
    import lbsm_pkg::*;
#(
    parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire item_t         item,
    output logic               done,
    output result_t            result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [IW-1:0] cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIMENSION);

    logic [CW-1:0] sw_reg;
    logic [CW-1:0] sh_reg;
    logic [CW-1:0] tw_reg;
    logic [CW-1:0] th_reg;
    logic [BW-1:0] bpp_reg;

    logic          accept;
    logic          cfg_write;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg  <= SIZE_RESET;
            sh_reg  <= SIZE_RESET;
            tw_reg  <= SIZE_RESET;
            th_reg  <= SIZE_RESET;
            bpp_reg <= BPP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SOURCE_WIDTH:    sw_reg  <= cfg_data[CW-1:0];
                REG_SOURCE_HEIGHT:   sh_reg  <= cfg_data[CW-1:0];
                REG_TARGET_WIDTH:    tw_reg  <= cfg_data[CW-1:0];
                REG_TARGET_HEIGHT:   th_reg  <= cfg_data[CW-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[BW-1:0];
                default:             ;
            endcase
        end
    end

    // stage 0: snapshot item and sizes
    logic s0_valid_reg;
    geo_t s0_geo_reg;
    geo_t s0_geo_next;

    always_comb
    begin
        s0_geo_next.ox   = item.out_x;
        s0_geo_next.oy   = item.out_y;
        s0_geo_next.sw   = sw_reg;
        s0_geo_next.sh   = sh_reg;
        s0_geo_next.tw   = tw_reg;
        s0_geo_next.th   = th_reg;
        s0_geo_next.bpp  = bpp_reg;
        s0_geo_next.tall = 1'b0;
        s0_geo_next.bad  = (tw_reg == '0) || (th_reg == '0)
                        || ({1'b0, tw_reg} > MAX_D) || ({1'b0, th_reg} > MAX_D)
                        || (sw_reg == '0) || (sh_reg == '0)
                        || ({1'b0, sw_reg} > MAX_D) || ({1'b0, sh_reg} > MAX_D)
                        || (bpp_reg == '0)
                        || ({1'b0, item.out_x} >= tw_reg)
                        || ({1'b0, item.out_y} >= th_reg);
    end

    // stage 1: cross products
    logic          s1_valid_reg;
    geo_t          s1_geo_reg;
    logic [OW-1:0] s1_wide_reg;
    logic [OW-1:0] s1_high_reg;

    // stage 2: pick the division
    logic          s2_valid_reg;
    geo_t          s2_geo_reg;
    geo_t          s2_geo_next;
    logic [OW-1:0] s2_num_reg;
    logic [OW-1:0] s2_num_next;
    logic [CW-1:0] s2_den_reg;
    logic [CW-1:0] s2_den_next;

    always_comb
    begin
        s2_geo_next      = s1_geo_reg;
        s2_geo_next.tall = {1'b0, s1_wide_reg}
                        >= ({1'b0, s1_high_reg} + (OW+1)'(s1_geo_reg.sw));
        s2_num_next      = s2_geo_next.tall ? s1_high_reg : s1_wide_reg;
        s2_den_next      = s2_geo_next.tall ? s1_geo_reg.sh : s1_geo_reg.sw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_geo_reg  <= s0_geo_next;
        s1_geo_reg  <= s0_geo_reg;
        s1_wide_reg <= OW'(s0_geo_reg.tw) * OW'(s0_geo_reg.sh);
        s1_high_reg <= OW'(s0_geo_reg.th) * OW'(s0_geo_reg.sw);
        s2_geo_reg  <= s2_geo_next;
        s2_num_reg  <= s2_num_next;
        s2_den_reg  <= s2_den_next;
    end

    logic          a_valid;
    logic [CW-1:0] a_quot;
    geo_t          a_geo;

    lbsm_div_chain #(
        .W  (CW),
        .PW ($bits(geo_t))
    ) u_size_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_num    (s2_num_reg),
        .in_div    (s2_den_reg),
        .in_pay    (s2_geo_reg),
        .out_valid (a_valid),
        .out_quot  (a_quot),
        .out_pay   (a_geo)
    );

    // stage 3: drawn area and origin
    logic          s3_valid_reg;
    geo_t          s3_geo_reg;
    logic [CW-1:0] s3_dw_reg;
    logic [CW-1:0] s3_dw_next;
    logic [CW-1:0] s3_dh_reg;
    logic [CW-1:0] s3_dh_next;
    logic [XW-1:0] s3_x0_reg;
    logic [XW-1:0] s3_x0_next;
    logic [XW-1:0] s3_y0_reg;
    logic [XW-1:0] s3_y0_next;
    logic          s3_ok_reg;
    logic          s3_ok_next;
    logic [CW-1:0] x_gap;
    logic [CW-1:0] y_gap;

    always_comb
    begin
        s3_dw_next = a_geo.tall ? a_quot : a_geo.tw;
        s3_dh_next = a_geo.tall ? a_geo.th : a_quot;
        x_gap      = a_geo.tw - s3_dw_next;
        y_gap      = a_geo.th - s3_dh_next;
        s3_x0_next = x_gap[CW-1:1];
        s3_y0_next = y_gap[CW-1:1];
        s3_ok_next = !a_geo.bad && (s3_dw_next != '0) && (s3_dh_next != '0);
    end

    // stage 4: position inside the drawn area
    logic          s4_valid_reg;
    map_t          s4_map_reg;
    map_t          s4_map_next;
    logic [CW-1:0] s4_sh_reg;
    logic [CW-1:0] s4_dw_reg;
    logic [CW-1:0] s4_dh_reg;
    logic [XW-1:0] s4_dx_reg;
    logic [XW-1:0] s4_dy_reg;
    logic          s4_inside_reg;
    logic          s4_inside_next;

    always_comb
    begin
        s4_map_next.ox  = s3_geo_reg.ox;
        s4_map_next.oy  = s3_geo_reg.oy;
        s4_map_next.sw  = s3_geo_reg.sw;
        s4_map_next.tw  = s3_geo_reg.tw;
        s4_map_next.bpp = s3_geo_reg.bpp;
        s4_map_next.ok  = s3_ok_reg;
        s4_inside_next  = (s3_geo_reg.ox >= s3_x0_reg)
            && ({2'b0, s3_geo_reg.ox} < ({2'b0, s3_x0_reg} + {1'b0, s3_dw_reg}))
            && (s3_geo_reg.oy >= s3_y0_reg)
            && ({2'b0, s3_geo_reg.oy} < ({2'b0, s3_y0_reg} + {1'b0, s3_dh_reg}));
    end

    // stage 5: scaled numerators
    logic          s5_valid_reg;
    map_t          s5_map_reg;
    logic          s5_inside_reg;
    logic [CW-1:0] s5_dw_reg;
    logic [CW-1:0] s5_dh_reg;
    logic [OW-1:0] s5_nx_reg;
    logic [OW-1:0] s5_ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= a_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_geo_reg    <= a_geo;
        s3_dw_reg     <= s3_dw_next;
        s3_dh_reg     <= s3_dh_next;
        s3_x0_reg     <= s3_x0_next;
        s3_y0_reg     <= s3_y0_next;
        s3_ok_reg     <= s3_ok_next;
        s4_map_reg    <= s4_map_next;
        s4_sh_reg     <= s3_geo_reg.sh;
        s4_dw_reg     <= s3_dw_reg;
        s4_dh_reg     <= s3_dh_reg;
        s4_dx_reg     <= s3_geo_reg.ox - s3_x0_reg;
        s4_dy_reg     <= s3_geo_reg.oy - s3_y0_reg;
        s4_inside_reg <= s4_inside_next;
        s5_map_reg    <= s4_map_reg;
        s5_inside_reg <= s4_inside_reg;
        s5_dw_reg     <= s4_dw_reg;
        s5_dh_reg     <= s4_dh_reg;
        s5_nx_reg     <= OW'(s4_dx_reg) * OW'(s4_map_reg.sw);
        s5_ny_reg     <= OW'(s4_dy_reg) * OW'(s4_sh_reg);
    end

    logic          bx_valid;
    logic [CW-1:0] bx_quot;
    map_t          bx_map;
    logic          cy_valid;
    logic [CW-1:0] cy_quot;
    logic          cy_inside;

    lbsm_div_chain #(
        .W  (CW),
        .PW ($bits(map_t))
    ) u_col_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_num    (s5_nx_reg),
        .in_div    (s5_dw_reg),
        .in_pay    (s5_map_reg),
        .out_valid (bx_valid),
        .out_quot  (bx_quot),
        .out_pay   (bx_map)
    );

    lbsm_div_chain #(
        .W  (CW),
        .PW (1)
    ) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_num    (s5_ny_reg),
        .in_div    (s5_dh_reg),
        .in_pay    (s5_inside_reg),
        .out_valid (cy_valid),
        .out_quot  (cy_quot),
        .out_pay   (cy_inside)
    );

    // stage 6: linear pixel indexes
    logic          s6_valid_reg;
    logic          s6_ok_reg;
    logic          s6_inside_reg;
    logic [CW-1:0] s6_sx_reg;
    logic [CW-1:0] s6_sy_reg;
    logic [BW-1:0] s6_bpp_reg;
    logic [OW-1:0] s6_src_lin_reg;
    logic [OW-1:0] s6_dst_lin_reg;

    // stage 7: byte offsets and gating
    logic          done_reg;
    result_t       result_reg;
    result_t       result_next;
    logic          pix;

    always_comb
    begin
        pix                         = s6_ok_reg && s6_inside_reg;
        result_next.geometry_ok     = s6_ok_reg;
        result_next.in_picture      = pix;
        result_next.src_x           = pix ? s6_sx_reg[XW-1:0] : '0;
        result_next.src_y           = pix ? s6_sy_reg[XW-1:0] : '0;
        result_next.src_byte_offset = pix ? OW'(s6_src_lin_reg * OW'(s6_bpp_reg)) : '0;
        result_next.dst_byte_offset = s6_ok_reg
                                    ? OW'(s6_dst_lin_reg * OW'(s6_bpp_reg)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= bx_valid;
            done_reg     <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_ok_reg      <= bx_map.ok;
        s6_inside_reg  <= cy_inside;
        s6_sx_reg      <= bx_quot;
        s6_sy_reg      <= cy_quot;
        s6_bpp_reg     <= bx_map.bpp;
        s6_src_lin_reg <= OW'(OW'(cy_quot) * OW'(bx_map.sw) + OW'(bx_quot));
        s6_dst_lin_reg <= OW'(OW'(bx_map.oy) * OW'(bx_map.tw) + OW'(bx_map.ox));
        result_reg     <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_rows_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        bx_valid == cy_valid)
        else $error("divider rows out of step");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching transfer");

    a_picture_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.in_picture |-> result.geometry_ok)
        else $error("picture pixel with bad geometry");

    a_background: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.in_picture |->
            result.src_x == '0 && result.src_y == '0 && result.src_byte_offset == '0)
        else $error("background pixel carries source fields");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.geometry_ok |-> result.dst_byte_offset == '0)
        else $error("target offset given for bad geometry");

endmodule

`default_nettype wire
